FILE: src/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg
// shared constants, operation codes and sequencer states for the ordered
// list engine
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int KIND_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  typedef enum logic [KIND_W-1:0] {
    K_INS_POS    = 4'd0,
    K_DEL_POS    = 4'd1,
    K_INS_FIRST  = 4'd2,
    K_INS_LAST   = 4'd3,
    K_DEL_FIRST  = 4'd4,
    K_DEL_LAST   = 4'd5,
    K_FIND_FIRST = 4'd6,
    K_FIND_LAST  = 4'd7,
    K_COUNT_KEY  = 4'd8
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DONE
  } state_t;

endpackage

FILE: src/bole_req_if.sv
// ----------------------------------------------------------------------------
// bole_req_if
// request channel: one list operation per request
// ----------------------------------------------------------------------------
interface bole_req_if
  import bole_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

FILE: src/bole_rsp_if.sv
// ----------------------------------------------------------------------------
// bole_rsp_if
// result channel: one result per request
// ----------------------------------------------------------------------------
interface bole_rsp_if
  import bole_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  removed_value;
  logic [COUNT_W-1:0]         found_position;
  logic [COUNT_W-1:0]         match_count;
  logic [COUNT_W-1:0]         entry_count;

  modport source (output valid, output status, output removed_value, output found_position,
                  output match_count, output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value, input found_position,
                  input match_count, input entry_count, output ready);
endinterface

FILE: src/bounded_ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top
// positional list of up to CAPACITY signed words held in one memory
//
// req carries one operation (kind, value, position); rsp returns exactly one
// result per request, in order. A small sequencer drives a single memory with
// one read and one write port; list shifts and key searches walk the memory
// entry by entry (read, then write back or compare).
// req is ready only in idle, so one request is in work at a time.
// The result sits in an output register; the next request is taken while it
// waits. If rsp stalls and a second result is ready, the sequencer holds it
// and stops taking requests until the output register frees.
// Reset empties the list and drops any pending result; the memory itself is
// not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top
  import bole_pkg::*;
(
  input logic       clk,
  input logic       rst,
  bole_req_if.sink  req,
  bole_rsp_if.source rsp
);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [DATA_WIDTH-1:0] mem_wd;
  logic [IDX_W-1:0]      mem_ra;

  state_t                state, state_next;
  logic [CNT_W-1:0]      occ, occ_next;
  logic [CNT_W-1:0]      cur, cur_next;
  logic [CNT_W-1:0]      tgt, tgt_next;
  logic [KIND_W-1:0]     op, op_next;
  logic [DATA_WIDTH-1:0] word, word_next;
  status_t               res_status, res_status_next;
  logic [VALUE_W-1:0]    res_removed, res_removed_next;
  logic [COUNT_W-1:0]    res_found, res_found_next;
  logic [COUNT_W-1:0]    res_matches, res_matches_next;

  logic                  out_valid;
  logic                  out_load;
  logic [STATUS_W-1:0]   out_status;
  logic [VALUE_W-1:0]    out_removed;
  logic [COUNT_W-1:0]    out_found;
  logic [COUNT_W-1:0]    out_matches;
  logic [COUNT_W-1:0]    out_count;

  logic [POS_W:0]        pos_ext;
  logic [POS_W:0]        occ_ext;
  logic                  full;
  logic [DATA_WIDTH-1:0] in_word;
  logic [CNT_W-1:0]      cur_dec;
  logic [CNT_W-1:0]      cur_inc;

  assign pos_ext = {1'b0, req.position};
  assign occ_ext = (POS_W + 1)'(occ);
  assign full    = (occ == CNT_W'(CAPACITY));
  assign in_word = DATA_WIDTH'(req.value);
  assign cur_dec = cur - CNT_W'(1);
  assign cur_inc = cur + CNT_W'(1);

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    cur         <= cur_next;
    tgt         <= tgt_next;
    op          <= op_next;
    word        <= word_next;
    res_status  <= res_status_next;
    res_removed <= res_removed_next;
    res_found   <= res_found_next;
    res_matches <= res_matches_next;
  end

  always_comb begin
    state_next       = state;
    occ_next         = occ;
    cur_next         = cur;
    tgt_next         = tgt;
    op_next          = op;
    word_next        = word;
    res_status_next  = res_status;
    res_removed_next = res_removed;
    res_found_next   = res_found;
    res_matches_next = res_matches;
    mem_we           = 1'b0;
    mem_wa           = cur[IDX_W-1:0];
    mem_wd           = rdata;
    mem_ra           = cur[IDX_W-1:0];
    req.ready        = 1'b0;
    out_load         = 1'b0;

    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          op_next          = req.kind;
          word_next        = in_word;
          res_status_next  = ST_OK;
          res_removed_next = '0;
          res_found_next   = '0;
          res_matches_next = '0;
          cur_next         = occ;
          state_next       = S_DONE;
          case (req.kind) inside
            K_INS_POS, K_INS_FIRST, K_INS_LAST: begin
              if (req.kind == K_INS_POS) begin
                tgt_next = CNT_W'(req.position - POS_W'(1));
              end else if (req.kind == K_INS_FIRST) begin
                tgt_next = '0;
              end else begin
                tgt_next = occ;
              end
              if (req.kind == K_INS_POS &&
                  (req.position == '0 || pos_ext > occ_ext + (POS_W + 1)'(1))) begin
                res_status_next = ST_BADPOS;
              end else if (full) begin
                res_status_next = ST_FULL;
              end else if (occ > tgt_next) begin
                state_next = S_INS_RD;
              end else begin
                state_next = S_INS_PUT;
              end
            end
            K_DEL_POS, K_DEL_FIRST, K_DEL_LAST: begin
              if (req.kind == K_DEL_POS) begin
                tgt_next = CNT_W'(req.position - POS_W'(1));
              end else if (req.kind == K_DEL_FIRST) begin
                tgt_next = '0;
              end else begin
                tgt_next = occ - CNT_W'(1);
              end
              cur_next = tgt_next;
              if (occ == '0) begin
                res_status_next  = ST_EMPTY;
                res_removed_next = '1;
              end else if (req.kind == K_DEL_POS &&
                           (req.position == '0 || pos_ext > occ_ext)) begin
                res_status_next  = ST_BADPOS;
                res_removed_next = '1;
              end else begin
                state_next = S_DEL_RD;
              end
            end
            K_FIND_FIRST, K_FIND_LAST, K_COUNT_KEY: begin
              cur_next = '0;
              if (occ != '0) begin
                state_next = S_SRCH_RD;
              end
            end
            default: begin
              // undefined kind: no operation
            end
          endcase
        end
      end

      // shift up: entry cur-1 moves to cur
      S_INS_RD: begin
        mem_ra     = cur_dec[IDX_W-1:0];
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        mem_we   = 1'b1;
        mem_wa   = cur[IDX_W-1:0];
        mem_wd   = rdata;
        cur_next = cur_dec;
        if (cur_dec > tgt) begin
          state_next = S_INS_RD;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_wa     = tgt[IDX_W-1:0];
        mem_wd     = word;
        occ_next   = occ + CNT_W'(1);
        state_next = S_DONE;
      end

      // first read returns the removed entry, later ones shift down
      S_DEL_RD: begin
        mem_ra     = cur[IDX_W-1:0];
        state_next = S_DEL_WR;
      end
      S_DEL_WR: begin
        if (cur == tgt) begin
          res_removed_next = VALUE_W'($signed(rdata));
        end else begin
          mem_we = 1'b1;
          mem_wa = cur_dec[IDX_W-1:0];
          mem_wd = rdata;
        end
        if (cur_inc < occ) begin
          cur_next   = cur_inc;
          state_next = S_DEL_RD;
        end else begin
          occ_next   = occ - CNT_W'(1);
          state_next = S_DONE;
        end
      end

      S_SRCH_RD: begin
        mem_ra     = cur[IDX_W-1:0];
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (rdata == word) begin
          res_matches_next = res_matches + COUNT_W'(1);
          if (op == K_FIND_LAST || res_found == '0) begin
            res_found_next = COUNT_W'(cur_inc);
          end
        end
        cur_next = cur_inc;
        if (cur_inc < occ) begin
          state_next = S_SRCH_RD;
        end else begin
          if (op == K_COUNT_KEY) begin
            res_found_next = '0;
          end else begin
            res_matches_next = '0;
          end
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status  <= res_status;
      out_removed <= res_removed;
      out_found   <= res_found;
      out_matches <= res_matches;
      out_count   <= COUNT_W'(occ);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.removed_value  = out_removed;
  assign rsp.found_position = out_found;
  assign rsp.match_count    = out_matches;
  assign rsp.entry_count    = out_count;

endmodule

FILE: tb/sv/tb_bounded_ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// tb_bounded_ordered_list_engine_top
// self-checking bench for the ordered list engine. a software copy of the list
// predicts every result. requests are sent in bursts with gaps, and the result
// side stalls on its own pattern with two long hold-offs that back up the
// block. the stimulus opens with a short directed run, then random phases that
// grow the list to full, shrink it to empty and mix both.
// ----------------------------------------------------------------------------

typedef struct packed {
  bole_pkg::status_t                       status;
  logic signed [bole_pkg::VALUE_W-1:0]     removed_value;
  logic [bole_pkg::COUNT_W-1:0]            found_position;
  logic [bole_pkg::COUNT_W-1:0]            match_count;
  logic [bole_pkg::COUNT_W-1:0]            entry_count;
} list_result_t;

class list_scoreboard;
  localparam int MAX_REPORTS = 40;

  logic signed [bole_pkg::DATA_WIDTH-1:0] cells[$];
  list_result_t                           awaited[$];
  int                                     mismatches;

  function new();
    mismatches = 0;
  endfunction

  function int size();
    return cells.size();
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  task report(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  // apply one accepted request to the list copy and queue its result
  function void note_request(input logic [bole_pkg::KIND_W-1:0] kind,
                             input logic [bole_pkg::VALUE_W-1:0] value,
                             input logic [bole_pkg::POS_W-1:0]   position);
    list_result_t                            r;
    logic signed [bole_pkg::DATA_WIDTH-1:0]  key;
    logic signed [bole_pkg::DATA_WIDTH-1:0]  taken;
    int                                      n;
    int                                      idx;
    int                                      i;
    int                                      hits;
    int                                      found;
    r = '0;
    r.status = bole_pkg::ST_OK;
    key = value[bole_pkg::DATA_WIDTH-1:0];
    n = cells.size();
    hits = 0;
    found = 0;
    case (kind)
      bole_pkg::K_INS_POS: begin
        // position check comes before the full check
        if (position == 0 || int'(position) > n + 1) r.status = bole_pkg::ST_BADPOS;
        else if (n >= bole_pkg::CAPACITY) r.status = bole_pkg::ST_FULL;
        else cells.insert(int'(position) - 1, key);
      end
      bole_pkg::K_INS_FIRST: begin
        if (n >= bole_pkg::CAPACITY) r.status = bole_pkg::ST_FULL;
        else cells.push_front(key);
      end
      bole_pkg::K_INS_LAST: begin
        if (n >= bole_pkg::CAPACITY) r.status = bole_pkg::ST_FULL;
        else cells.push_back(key);
      end
      bole_pkg::K_DEL_POS, bole_pkg::K_DEL_FIRST, bole_pkg::K_DEL_LAST: begin
        if (n == 0) begin
          r.status = bole_pkg::ST_EMPTY;
          r.removed_value = -1;
        end else if (kind == bole_pkg::K_DEL_POS && (position == 0 || int'(position) > n)) begin
          r.status = bole_pkg::ST_BADPOS;
          r.removed_value = -1;
        end else begin
          if (kind == bole_pkg::K_DEL_POS) idx = int'(position) - 1;
          else if (kind == bole_pkg::K_DEL_FIRST) idx = 0;
          else idx = n - 1;
          taken = cells[idx];
          r.removed_value = taken;
          cells.delete(idx);
        end
      end
      bole_pkg::K_FIND_FIRST, bole_pkg::K_FIND_LAST, bole_pkg::K_COUNT_KEY: begin
        for (i = 0; i < n; i++) begin
          if (cells[i] == key) begin
            hits++;
            if (kind == bole_pkg::K_FIND_LAST || found == 0) found = i + 1;
          end
        end
        if (kind == bole_pkg::K_COUNT_KEY) r.match_count = bole_pkg::COUNT_W'(hits);
        else r.found_position = bole_pkg::COUNT_W'(found);
      end
      default: ;
    endcase
    r.entry_count = bole_pkg::COUNT_W'(cells.size());
    awaited.push_back(r);
  endfunction

  task check_result(input list_result_t got);
    list_result_t want;
    if (awaited.size() == 0) begin
      report($sformatf("result with no request outstanding, status %0d count %0d",
                       got.status, got.entry_count));
      return;
    end
    want = awaited.pop_front();
    if (got.status !== want.status)
      report($sformatf("status got %0d expected %0d", got.status, want.status));
    if (got.removed_value !== want.removed_value)
      report($sformatf("removed_value got %0h expected %0h", got.removed_value,
                       want.removed_value));
    if (got.found_position !== want.found_position)
      report($sformatf("found_position got %0d expected %0d", got.found_position,
                       want.found_position));
    if (got.match_count !== want.match_count)
      report($sformatf("match_count got %0d expected %0d", got.match_count,
                       want.match_count));
    if (got.entry_count !== want.entry_count)
      report($sformatf("entry_count got %0d expected %0d", got.entry_count,
                       want.entry_count));
  endtask
endclass

module tb_bounded_ordered_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bole_pkg::*;

  localparam int RANDOM_REQUESTS = 1650;
  localparam int PHASE_LEN       = 110;
  localparam int LONG_HOLD       = 600;
  localparam int HOLD_SPACING    = 700;
  localparam int DRAIN_CYCLES    = 300;
  localparam int CYCLE_LIMIT     = 2_000_000;

  localparam logic [KIND_W-1:0] KIND_UNDEF_LO = 4'd9;
  localparam logic [KIND_W-1:0] KIND_UNDEF_HI = 4'd15;

  // small key set so that searches and counts find repeats
  localparam logic [VALUE_W-1:0] KEY_POOL [0:7] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_002A, 32'hFFFF_FF9C
  };

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   results_seen = 0;
  int   burst_left = 0;

  list_scoreboard sb;

  bole_req_if req();
  bole_rsp_if rsp();

  bounded_ordered_list_engine_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin : monitor
    list_result_t got;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got.status         = status_t'(rsp.status);
        got.removed_value  = rsp.removed_value;
        got.found_position = rsp.found_position;
        got.match_count    = rsp.match_count;
        got.entry_count    = rsp.entry_count;
        sb.check_result(got);
        results_seen++;
      end
      if (req.valid && req.ready) sb.note_request(req.kind, req.value, req.position);
    end
  end

  // result side: own stall pattern plus long hold-offs so the block backs up
  initial begin : receiver
    int hold_left;
    int pat_left;
    int pat_mode;
    int next_hold_at;
    hold_left = 0;
    pat_left = 0;
    pat_mode = 0;
    next_hold_at = 300;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at += HOLD_SPACING;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(8, 60);
        end
        pat_left--;
        case (pat_mode)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= ($urandom_range(0, 3) != 0);
          2: rsp.ready <= 1'($urandom_range(0, 1));
          default: rsp.ready <= (pat_left % 5 == 0);
        endcase
      end
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at a falling edge after the request
  // is taken, with a random gap once the current burst runs out
  task automatic drive_request(input logic [KIND_W-1:0]  kind,
                               input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0]   position);
    int gap;
    req.valid    <= 1'b1;
    req.kind     <= kind;
    req.value    <= value;
    req.position <= position;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(0, 10);
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 1) return KEY_POOL[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // phase 0 grows toward full, phase 1 drains toward empty, phase 2 mixes
  task automatic issue_random(input int phase);
    int                 n;
    int                 roll;
    int                 ins_pct;
    int                 del_pct;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    n = sb.size();
    case (phase)
      0: begin ins_pct = 70; del_pct = 10; end
      1: begin ins_pct = 10; del_pct = 70; end
      default: begin ins_pct = 35; del_pct = 35; end
    endcase
    roll = $urandom_range(0, 99);
    value = pick_value();
    position = POS_W'($urandom_range(0, 255));
    if (roll < 6) begin
      // noise: any code, wild position
      kind = KIND_W'($urandom_range(0, 15));
      value = $urandom;
    end else if (roll < 6 + ins_pct) begin
      case ($urandom_range(0, 2))
        0: begin
          kind = K_INS_POS;
          position = POS_W'($urandom_range(1, n + 1));
        end
        1: kind = K_INS_FIRST;
        default: kind = K_INS_LAST;
      endcase
    end else if (roll < 6 + ins_pct + del_pct) begin
      case ($urandom_range(0, 2))
        0: begin
          kind = K_DEL_POS;
          position = POS_W'($urandom_range(1, (n > 0) ? n : 1));
        end
        1: kind = K_DEL_FIRST;
        default: kind = K_DEL_LAST;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: kind = K_FIND_FIRST;
        1: kind = K_FIND_LAST;
        default: kind = K_COUNT_KEY;
      endcase
    end
    drive_request(kind, value, position);
  endtask

  initial begin : stimulus
    int i;
    sb = new();
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.kind     = '0;
    req.value    = '0;
    req.position = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list: deletes and searches, empty wins over a bad position
    drive_request(K_DEL_FIRST,  32'h0, 8'd0);
    drive_request(K_DEL_LAST,   32'h0, 8'd0);
    drive_request(K_DEL_POS,    32'h0, 8'd0);
    drive_request(K_FIND_FIRST, 32'h0, 8'd1);
    drive_request(K_COUNT_KEY,  32'h0, 8'd1);
    // bad insert positions
    drive_request(K_INS_POS,    32'h1234_5678, 8'd0);
    drive_request(K_INS_POS,    32'h1234_5678, 8'd2);
    // build 7fffffff 0 80000000 ffffffff 7fffffff
    drive_request(K_INS_POS,    32'h8000_0000, 8'd1);
    drive_request(K_INS_FIRST,  32'h7FFF_FFFF, 8'd0);
    drive_request(K_INS_LAST,   32'hFFFF_FFFF, 8'd0);
    drive_request(K_INS_POS,    32'h7FFF_FFFF, 8'd4);
    drive_request(K_INS_POS,    32'h0000_0000, 8'd2);
    drive_request(K_FIND_FIRST, 32'h7FFF_FFFF, 8'd0);
    drive_request(K_FIND_LAST,  32'h7FFF_FFFF, 8'd0);
    drive_request(K_COUNT_KEY,  32'h7FFF_FFFF, 8'd0);
    drive_request(K_FIND_LAST,  32'h0000_3039, 8'd0);
    // bad delete positions, then a valid delete at position 3
    drive_request(K_DEL_POS,    32'h0, 8'd0);
    drive_request(K_DEL_POS,    32'h0, 8'd6);
    drive_request(K_DEL_POS,    32'h0, 8'd255);
    drive_request(K_DEL_POS,    32'h0, 8'd3);
    // undefined codes leave the list alone
    drive_request(KIND_UNDEF_LO, 32'h5555_5555, 8'd1);
    drive_request(KIND_UNDEF_HI, 32'hFFFF_FFFF, 8'd255);
    // drain down through the single-entry case
    drive_request(K_DEL_LAST,   32'h0, 8'd0);
    drive_request(K_DEL_FIRST,  32'h0, 8'd0);
    drive_request(K_DEL_FIRST,  32'h0, 8'd0);
    drive_request(K_DEL_LAST,   32'h0, 8'd0);
    drive_request(K_FIND_FIRST, 32'hFFFF_FFFF, 8'd0);

    for (i = 0; i < RANDOM_REQUESTS; i++) issue_random((i / PHASE_LEN) % 3);

    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bole_pkg.sv
src/bole_req_if.sv
src/bole_rsp_if.sv
src/bounded_ordered_list_engine_top.sv
tb/sv/tb_bounded_ordered_list_engine_top.sv
